/* hdl/tfli_pkg.sv */
package tfli_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int PREVIEW_ROWS  = 100;
  localparam int ENTRY_SPAN    = TABLE_ENTRIES - 1;

  // red, green, blue, alpha
  localparam int LANES      = 4;
  localparam int LANE_ALPHA = 3;
  localparam int COLOR_LANES = 3;

  localparam int SEG_STAGES = 3;
  localparam int DIV_STEPS  = 8;
  localparam int CMP_W      = 20;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_0   = 3'd0,
    REG_COLOR_1   = 3'd1,
    REG_COLOR_2   = 3'd2,
    REG_OPACITY_0 = 3'd3,
    REG_OPACITY_1 = 3'd4,
    REG_OPACITY_2 = 3'd5
  } reg_index_t;

  localparam logic [31:0] COLOR_0_RST   = 32'h0000_00FF;
  localparam logic [31:0] COLOR_1_RST   = 32'h8000_FF00;
  localparam logic [31:0] COLOR_2_RST   = 32'hFFFF_0000;
  localparam logic [15:0] OPACITY_0_RST = 16'h0000;
  localparam logic [15:0] OPACITY_1_RST = 16'h8080;
  localparam logic [15:0] OPACITY_2_RST = 16'hFFFF;

  typedef struct packed {
    logic [7:0] entry_index;
    logic [6:0] preview_row;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] preview_red;
    logic [7:0] preview_green;
    logic [7:0] preview_blue;
  } out_t;

  // one divide request per lane: quotient = num / den, or ovr_val when ovr
  typedef struct packed {
    logic [15:0] num;
    logic [7:0]  den;
    logic        ovr;
    logic [7:0]  ovr_val;
  } div_req_t;

  // index -> 8-bit position, saturating at the last entry
  function automatic logic [255:0][7:0] build_pos_table();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) begin
      if (i >= ENTRY_SPAN) begin
        t[i] = 8'd255;
      end else begin
        t[i] = 8'((i * 255) / ENTRY_SPAN);
      end
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] POS_TABLE = build_pos_table();

endpackage

/* hdl/tfli_segment.sv */
module tfli_segment
  import tfli_pkg::*;
(
  input  logic                        clk,
  input  logic [7:0]                  entry_index,
  input  logic [2:0][31:0]            color_point,
  input  logic [2:0][15:0]            opacity_point,
  output div_req_t [LANES-1:0]        req
);

  typedef struct packed {
    logic [7:0] l;
    logic [7:0] r;
    logic [7:0] pl;
    logic [7:0] pr;
  } ends_t;

  typedef struct packed {
    logic signed [17:0] prod_l;
    logic signed [17:0] prod_r;
    logic signed [8:0]  den;
    logic [7:0]         l;
  } prod_t;

  ends_t [LANES-1:0] ends;
  logic  [7:0]       pos;
  prod_t [LANES-1:0] prod;

  ends_t [LANES-1:0] ends_next;
  logic  [7:0]       pos_next;
  logic              color_hi;
  logic              opac_hi;

  // stage 1: position lookup and segment choice
  always_comb begin
    pos_next = POS_TABLE[entry_index];
    color_hi = pos_next > color_point[1][31:24];
    opac_hi  = pos_next > opacity_point[1][15:8];
    for (int k = 0; k < COLOR_LANES; k++) begin
      if (color_hi) begin
        ends_next[k].l  = color_point[1][16-8*k +: 8];
        ends_next[k].r  = color_point[2][16-8*k +: 8];
        ends_next[k].pl = color_point[1][31:24];
        ends_next[k].pr = color_point[2][31:24];
      end else begin
        ends_next[k].l  = color_point[0][16-8*k +: 8];
        ends_next[k].r  = color_point[1][16-8*k +: 8];
        ends_next[k].pl = color_point[0][31:24];
        ends_next[k].pr = color_point[1][31:24];
      end
    end
    if (opac_hi) begin
      ends_next[LANE_ALPHA].l  = opacity_point[1][7:0];
      ends_next[LANE_ALPHA].r  = opacity_point[2][7:0];
      ends_next[LANE_ALPHA].pl = opacity_point[1][15:8];
      ends_next[LANE_ALPHA].pr = opacity_point[2][15:8];
    end else begin
      ends_next[LANE_ALPHA].l  = opacity_point[0][7:0];
      ends_next[LANE_ALPHA].r  = opacity_point[1][7:0];
      ends_next[LANE_ALPHA].pl = opacity_point[0][15:8];
      ends_next[LANE_ALPHA].pr = opacity_point[1][15:8];
    end
  end

  // stage 2: weighted ends
  function automatic prod_t lane_prod(ends_t e, logic [7:0] p);
    prod_t             o;
    logic signed [8:0] dl;
    logic signed [8:0] dr;
    dl       = $signed({1'b0, e.pr}) - $signed({1'b0, p});
    dr       = $signed({1'b0, p}) - $signed({1'b0, e.pl});
    o.prod_l = 18'($signed({1'b0, e.l})) * 18'(dl);
    o.prod_r = 18'($signed({1'b0, e.r})) * 18'(dr);
    o.den    = $signed({1'b0, e.pr}) - $signed({1'b0, e.pl});
    o.l      = e.l;
    return o;
  endfunction

  // stage 3: sum, fold sign of span into numerator, catch the easy cases
  function automatic div_req_t lane_req(prod_t x);
    div_req_t           o;
    logic signed [18:0] sum;
    logic signed [18:0] snum;
    logic        [8:0]  dabs;
    sum  = 19'(x.prod_l) + 19'(x.prod_r);
    snum = x.den[8] ? -sum : sum;
    dabs = x.den[8] ? 9'(-x.den) : 9'(x.den);
    o.num     = snum[15:0];
    o.den     = dabs[7:0];
    o.ovr     = 1'b0;
    o.ovr_val = 8'd0;
    if (x.den == 9'sd0) begin
      o.ovr     = 1'b1;
      o.ovr_val = x.l;
    end else if (snum[18]) begin
      o.ovr     = 1'b1;
      o.ovr_val = 8'd0;
    end else if (snum[17:8] >= {2'b00, dabs[7:0]}) begin
      o.ovr     = 1'b1;
      o.ovr_val = 8'd255;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    ends <= ends_next;
    pos  <= pos_next;
    for (int k = 0; k < LANES; k++) begin
      prod[k] <= lane_prod(ends[k], pos);
      req[k]  <= lane_req(prod[k]);
    end
  end

endmodule

/* hdl/tfli_divider.sv */
module tfli_divider
  import tfli_pkg::*;
(
  input  logic       clk,
  input  div_req_t   req,
  output logic [7:0] quotient
);

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] lo;
    logic [7:0] quo;
    logic [7:0] den;
    logic       ovr;
    logic [7:0] ovr_val;
  } div_state_t;

  div_state_t st [DIV_STEPS];
  div_state_t first;

  // one restoring step; numerator is known below den*256 unless ovr
  function automatic div_state_t div_step(div_state_t s);
    div_state_t n;
    logic [8:0] t;
    n = s;
    t = {s.rem, s.lo[7]};
    if (t >= {1'b0, s.den}) begin
      n.rem = 8'(t - {1'b0, s.den});
      n.quo = {s.quo[6:0], 1'b1};
    end else begin
      n.rem = t[7:0];
      n.quo = {s.quo[6:0], 1'b0};
    end
    n.lo = {s.lo[6:0], 1'b0};
    return n;
  endfunction

  always_comb begin
    first.rem     = req.num[15:8];
    first.lo      = req.num[7:0];
    first.quo     = 8'd0;
    first.den     = req.den;
    first.ovr     = req.ovr;
    first.ovr_val = req.ovr_val;
  end

  always_ff @(posedge clk) begin
    st[0] <= div_step(first);
    for (int k = 1; k < DIV_STEPS; k++) begin
      st[k] <= div_step(st[k-1]);
    end
  end

  assign quotient = st[DIV_STEPS-1].ovr ? st[DIV_STEPS-1].ovr_val : st[DIV_STEPS-1].quo;

endmodule

/* hdl/tfli_preview.sv */
module tfli_preview
  import tfli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  input  logic [6:0]            row,
  input  logic [LANES-1:0][7:0] quo,
  output logic                  done,
  output out_t                  result
);

  localparam logic [CMP_W-1:0] ROW_SCALE = CMP_W'(255);
  localparam logic [CMP_W-1:0] ROW_COUNT = CMP_W'(PREVIEW_ROWS);

  logic [CMP_W-1:0] row_term;
  logic [CMP_W-1:0] alpha_term;
  logic             plain;
  out_t             result_next;

  function automatic logic [7:0] to_white(logic [7:0] c);
    logic [8:0] t;
    t = 9'd255 + {1'b0, c};
    return t[8:1];
  endfunction

  always_comb begin
    row_term   = CMP_W'(row) * ROW_SCALE;
    alpha_term = CMP_W'(quo[LANE_ALPHA]) * ROW_COUNT;
    plain      = row_term > alpha_term;
    result_next.red           = quo[0];
    result_next.green         = quo[1];
    result_next.blue          = quo[2];
    result_next.alpha         = quo[LANE_ALPHA];
    result_next.preview_red   = plain ? quo[0] : to_white(quo[0]);
    result_next.preview_green = plain ? quo[1] : to_white(quo[1]);
    result_next.preview_blue  = plain ? quo[2] : to_white(quo[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
    result <= result_next;
  end

endmodule

/* hdl/transfer_function_lut_interpolator_core.sv */
// channel | dir | handshake             | word
// --------+-----+-----------------------+-----------------------------------------
// item    | in  | start & !busy         | entry_index, preview_row
// result  | out | done, one cycle       | red, green, blue, alpha, preview rgb
// cfg     | in  | cfg_write             | cfg_index selects register, cfg_data
//
// A word taken at one edge passes the input register, three segment stages,
// eight divide steps (one quotient bit each) and the output stage to result.
// One word every cycle; busy stays low.
// Reset clears the valid line and loads the breakpoint defaults.
// Results carry no back-pressure: done is a one-cycle strobe.
module transfer_function_lut_interpolator_core
  import tfli_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_t                    item,
  output logic                   done,
  output out_t                   result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LINE    = SEG_STAGES + DIV_STEPS;
  localparam int LATENCY = LINE + 2;

  logic [2:0][31:0]       color_point;
  logic [2:0][15:0]       opacity_point;

  logic                   in_vld;
  in_t                    in_word;
  logic [LINE-1:0]        vld_line;
  logic [6:0]             row_line [LINE];

  div_req_t [LANES-1:0]   req;
  logic [LANES-1:0][7:0]  quo;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_point[0]   <= COLOR_0_RST;
      color_point[1]   <= COLOR_1_RST;
      color_point[2]   <= COLOR_2_RST;
      opacity_point[0] <= OPACITY_0_RST;
      opacity_point[1] <= OPACITY_1_RST;
      opacity_point[2] <= OPACITY_2_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLOR_0:   color_point[0]   <= cfg_data;
        REG_COLOR_1:   color_point[1]   <= cfg_data;
        REG_COLOR_2:   color_point[2]   <= cfg_data;
        REG_OPACITY_0: opacity_point[0] <= cfg_data[15:0];
        REG_OPACITY_1: opacity_point[1] <= cfg_data[15:0];
        REG_OPACITY_2: opacity_point[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // valid and row ride alongside the segment and divide stages
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      vld_line <= '0;
    end else begin
      in_vld   <= start && !busy;
      vld_line <= {vld_line[LINE-2:0], in_vld};
    end
    in_word     <= item;
    row_line[0] <= in_word.preview_row;
    for (int k = 1; k < LINE; k++) begin
      row_line[k] <= row_line[k-1];
    end
  end

  tfli_segment u_segment (
    .clk           (clk),
    .entry_index   (in_word.entry_index),
    .color_point   (color_point),
    .opacity_point (opacity_point),
    .req           (req)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tfli_divider u_divider (
      .clk      (clk),
      .req      (req[g]),
      .quotient (quo[g])
    );
  end

  tfli_preview u_preview (
    .clk    (clk),
    .rst    (rst),
    .valid  (vld_line[LINE-1]),
    .row    (row_line[LINE-1]),
    .quo    (quo),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not come out on time");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld_line[LINE-1]))
    else $error("result strobe without a word in flight");

  a_whiter: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.preview_red >= result.red) && (result.preview_green >= result.green)
             && (result.preview_blue >= result.blue))
    else $error("preview pixel darker than colour");
`endif

endmodule
